### rtl/tsp_nearest_neighbor_two_opt_macros.svh
// ----------------------------------------------------------------------------
// TSP solver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef TSP_NEAREST_NEIGHBOR_TWO_OPT_MACROS_SVH
`define TSP_NEAREST_NEIGHBOR_TWO_OPT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// TSP solver package
// Widths, register indexes and the start city helper of the TSP solver.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned MAX_CITIES  = 32;
  localparam int unsigned CITY_W      = 5;
  localparam int unsigned NCNT_W      = 6;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned STORE_DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned ENTRY_W     = 11;
  localparam int unsigned LEN_W       = 21;
  localparam int unsigned PASS_W      = 8;
  localparam int unsigned NUM_STARTS  = 5;
  localparam int unsigned START_W     = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  // Reciprocal of the start count: x / 5 == (x * 205) >> 10 for x up to 128
  localparam int unsigned DIV_MUL     = 205;
  localparam int unsigned DIV_SHIFT   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASSES = 4'd1;

  localparam logic [PASS_W-1:0] MAX_PASSES_RST = 8'd255;

  typedef logic [CITY_W-1:0] city_t;
  typedef logic [NCNT_W-1:0] idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Start city s: s itself for small problems, else s*n/5
  function automatic city_t start_city(logic [START_W-1:0] s, idx_t n);
    logic [8:0]  prod;
    logic [16:0] scaled;
    prod   = 9'(s) * 9'(n);
    scaled = 17'(prod) * 17'(DIV_MUL);
    if (n <= NCNT_W'(NUM_STARTS)) begin
      return CITY_W'(s);
    end
    return CITY_W'(scaled >> DIV_SHIFT);
  endfunction

endpackage

### rtl/tsp_if.sv
// ----------------------------------------------------------------------------
// TSP solver channels
// Valid/ready channels for matrix entries, tour words and register writes.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  import tsp_pkg::*;
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  last_entry;
  modport source (output valid, output distance, output last_entry, input ready);
  modport sink   (input valid, input distance, input last_entry, output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;
  logic  valid;
  logic  ready;
  city_t city;
  len_t  tour_length;
  logic  empty_tour;
  logic  last_city;
  modport source (output valid, output city, output tour_length, output empty_tour,
                  output last_city, input ready);
  modport sink   (input valid, input city, input tour_length, input empty_tour,
                  input last_city, output ready);
endinterface

interface tsp_cfg_if;
  import tsp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tsp_ram.sv
// ----------------------------------------------------------------------------
// TSP solver RAM
// Simple dual port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tsp_nearest_neighbor_two_opt.sv
// ----------------------------------------------------------------------------
// TSP solver: nearest neighbour construction with 2-opt improvement
// Loads a distance matrix, solves from up to five starts, emits the best tour.
// ----------------------------------------------------------------------------
//  channel | dir | words carried                       | handshake
//  --------+-----+-------------------------------------+------------------
//  in_i    | in  | distance, last_entry (one entry)    | valid/ready
//  out_o   | out | city, tour_length, empty_tour, last | valid/ready
//  cfg_i   | in  | index, data (register write)        | valid/ready, ready=1
//
//  Loading accepts one matrix word per cycle while idle; the distance store has one write port.
//  Solve per start: nearest neighbour construction, 2-opt passes over edge pairs
//  with swaps of city pairs, the tour length, a compare with the best, a copy of
//  the tour and the move on; all through one read port of the store.
//  Output reads, loads and holds each city word until out_o takes it.
//  Reset is asynchronous, active low; stores need no clearing pass.
// ----------------------------------------------------------------------------
`include "tsp_nearest_neighbor_two_opt_macros.svh"

module tsp_nearest_neighbor_two_opt (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsp_in_if.sink       in_i,
  tsp_out_if.source    out_o,
  tsp_cfg_if.sink      cfg_i
);
  import tsp_pkg::*;

  // Sequencer codes
  localparam logic [4:0] ST_IDLE       = 5'd0;
  localparam logic [4:0] ST_NN_INIT    = 5'd1;
  localparam logic [4:0] ST_NN_SCAN    = 5'd2;
  localparam logic [4:0] ST_NN_NEXT    = 5'd3;
  localparam logic [4:0] ST_OPT_START  = 5'd4;
  localparam logic [4:0] ST_PASS_BEGIN = 5'd5;
  localparam logic [4:0] ST_T_RD       = 5'd6;
  localparam logic [4:0] ST_D_RD       = 5'd7;
  localparam logic [4:0] ST_CMP        = 5'd8;
  localparam logic [4:0] ST_REV        = 5'd9;
  localparam logic [4:0] ST_NEXT_J     = 5'd10;
  localparam logic [4:0] ST_LEN_A      = 5'd11;
  localparam logic [4:0] ST_LEN_B      = 5'd12;
  localparam logic [4:0] ST_LEN_C      = 5'd13;
  localparam logic [4:0] ST_BEST       = 5'd14;
  localparam logic [4:0] ST_COPY       = 5'd15;
  localparam logic [4:0] ST_NEXT_S     = 5'd16;
  localparam logic [4:0] ST_OUT_RD     = 5'd17;
  localparam logic [4:0] ST_OUT_LD     = 5'd18;
  localparam logic [4:0] ST_OUT_WAIT   = 5'd19;

  localparam logic [MAX_CITIES-1:0] ONE_HOT0 = MAX_CITIES'(1);

  // Control state
  logic [4:0]            state_q, state_d;
  logic [ENTRY_W-1:0]    entry_q, entry_d;
  idx_t                  city_count_q;
  logic [PASS_W-1:0]     max_passes_q;
  logic [MAX_CITIES-1:0] visited_q, visited_d;
  idx_t                  n_q, n_d;
  logic [START_W-1:0]    s_q, s_d;
  idx_t                  step_q, step_d, scan_q, scan_d;
  logic                  jp_v_q, jp_v_d, found_q, found_d;
  logic [PASS_W-1:0]     passes_q, passes_d;
  logic                  changed_q, changed_d;
  idx_t                  i_q, i_d, j_q, j_d, k_q, k_d, l_q, l_d, r_q, r_d;
  logic [2:0]            sub_q, sub_d;
  logic                  best_v_q, best_v_d;
  logic                  out_valid_q, out_valid_d;

  // Datapath registers
  city_t                 cur_q, cur_d, jp_q, jp_d, bn_q, bn_d, prev_q, prev_d, tl_q, tl_d;
  city_t                 ci_q, ci_d, ci1_q, ci1_d, cj_q, cj_d, cj1_q, cj1_d;
  dist_t                 bd_q, bd_d;
  logic [DIST_W:0]       nw_q, nw_d, od_q, od_d;
  len_t                  total_q, total_d, best_q, best_d;
  city_t                 out_city_q, out_city_d;
  len_t                  out_len_q, out_len_d;
  logic                  out_empty_q, out_empty_d, out_last_q, out_last_d;

  // Memory ports
  city_t                 dist_a, dist_b;
  logic [ENTRY_W-1:0]    dist_lin;
  dist_t                 dist_rdata;
  logic                  dist_we;
  city_t                 tour_raddr, tour_waddr, tour_wdata, tour_rdata;
  logic                  tour_we;
  city_t                 best_raddr, best_waddr, best_wdata, best_rdata;
  logic                  best_we;

  logic                  in_acc, out_acc;
  logic [ENTRY_W-1:0]    cnt_next;
  logic [11:0]           n_sq;
  logic                  n_bad;
  city_t                 start_c;
  idx_t                  j1, starts;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.city        = out_city_q;
  assign out_o.tour_length = out_len_q;
  assign out_o.empty_tour  = out_empty_q;
  assign out_o.last_city   = out_last_q;

  // Saturate the entry count one past the store so an oversize load still mismatches
  assign cnt_next = (entry_q <= ENTRY_W'(STORE_DEPTH)) ? entry_q + 1'b1 : entry_q;
  assign n_sq     = 12'(city_count_q) * 12'(city_count_q);
  assign n_bad    = (city_count_q < NCNT_W'(2)) || (city_count_q > NCNT_W'(MAX_CITIES)) ||
                    ({1'b0, cnt_next} != n_sq);
  assign dist_we  = in_acc && (entry_q < ENTRY_W'(STORE_DEPTH));

  // Row-major address a*n+b; stays below the store depth for a, b < n
  assign dist_lin = ENTRY_W'(dist_a) * ENTRY_W'(n_q) + ENTRY_W'(dist_b);

  assign start_c = start_city(s_q, n_q);
  assign j1      = (j_q + 1'b1 == n_q) ? '0 : j_q + 1'b1;
  assign starts  = (n_q <= NCNT_W'(NUM_STARTS)) ? n_q : NCNT_W'(NUM_STARTS);

  tsp_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DIST_W)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (entry_q[ADDR_W-1:0]),
    .wdata_i (in_i.distance),
    .raddr_i (dist_lin[ADDR_W-1:0]),
    .rdata_o (dist_rdata)
  );

  tsp_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_tour_ram (
    .clk_i   (clk_i),
    .we_i    (tour_we),
    .waddr_i (tour_waddr),
    .wdata_i (tour_wdata),
    .raddr_i (tour_raddr),
    .rdata_o (tour_rdata)
  );

  tsp_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata)
  );

  // Sequencer: every step drives at most one read of each store
  always_comb begin
    state_d = state_q;  entry_d = entry_q;  visited_d = visited_q;
    n_d = n_q;  s_d = s_q;  step_d = step_q;  scan_d = scan_q;
    jp_v_d = jp_v_q;  found_d = found_q;  passes_d = passes_q;  changed_d = changed_q;
    i_d = i_q;  j_d = j_q;  k_d = k_q;  l_d = l_q;  r_d = r_q;  sub_d = sub_q;
    best_v_d = best_v_q;  out_valid_d = out_valid_q;
    cur_d = cur_q;  jp_d = jp_q;  bn_d = bn_q;  prev_d = prev_q;  tl_d = tl_q;
    ci_d = ci_q;  ci1_d = ci1_q;  cj_d = cj_q;  cj1_d = cj1_q;  bd_d = bd_q;
    nw_d = nw_q;  od_d = od_q;  total_d = total_q;  best_d = best_q;
    out_city_d = out_city_q;  out_len_d = out_len_q;
    out_empty_d = out_empty_q;  out_last_d = out_last_q;
    dist_a = '0;  dist_b = '0;
    tour_raddr = '0;  tour_we = 1'b0;  tour_waddr = '0;  tour_wdata = '0;
    best_raddr = '0;  best_we = 1'b0;  best_waddr = '0;  best_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          entry_d = cnt_next;
          if (in_i.last_entry) begin
            entry_d = '0;
            if (n_bad) begin
              // No tour: one empty word
              out_city_d  = '0;
              out_len_d   = '0;
              out_empty_d = 1'b1;
              out_last_d  = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_OUT_WAIT;
            end else begin
              n_d      = city_count_q;
              s_d      = '0;
              best_v_d = 1'b0;
              state_d  = ST_NN_INIT;
            end
          end
        end
      end
      ST_NN_INIT: begin
        cur_d      = start_c;
        visited_d  = ONE_HOT0 << start_c;
        tour_we    = 1'b1;
        tour_waddr = '0;
        tour_wdata = start_c;
        step_d     = NCNT_W'(1);
        scan_d     = '0;
        jp_v_d     = 1'b0;
        found_d    = 1'b0;
        state_d    = ST_NN_SCAN;
      end
      ST_NN_SCAN: begin
        // Compare the word read last cycle; strict less keeps the lowest index
        if (jp_v_q && (!found_q || dist_rdata < bd_q)) begin
          found_d = 1'b1;
          bd_d    = dist_rdata;
          bn_d    = jp_q;
        end
        dist_a = cur_q;
        dist_b = CITY_W'(scan_q);
        jp_d   = CITY_W'(scan_q);
        jp_v_d = (scan_q < n_q) && !visited_q[scan_q[CITY_W-1:0]];
        if (scan_q == n_q) begin
          state_d = ST_NN_NEXT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_NN_NEXT: begin
        visited_d  = visited_q | (ONE_HOT0 << bn_q);
        tour_we    = 1'b1;
        tour_waddr = CITY_W'(step_q);
        tour_wdata = bn_q;
        cur_d      = bn_q;
        step_d     = step_q + 1'b1;
        if (step_q + 1'b1 == n_q) begin
          state_d = ST_OPT_START;
        end else begin
          scan_d  = '0;
          jp_v_d  = 1'b0;
          found_d = 1'b0;
          state_d = ST_NN_SCAN;
        end
      end
      ST_OPT_START: begin
        if ((n_q < NCNT_W'(4)) || (max_passes_q == '0)) begin
          k_d     = '0;
          total_d = '0;
          state_d = ST_LEN_A;
        end else begin
          passes_d = '0;
          state_d  = ST_PASS_BEGIN;
        end
      end
      ST_PASS_BEGIN: begin
        changed_d = 1'b0;
        passes_d  = passes_q + 1'b1;
        i_d       = '0;
        j_d       = NCNT_W'(2);
        sub_d     = '0;
        state_d   = ST_T_RD;
      end
      ST_T_RD: begin
        // Fetch the four cities of the candidate edge pair
        case (sub_q)
          3'd0:    tour_raddr = CITY_W'(i_q);
          3'd1:    tour_raddr = CITY_W'(i_q + 1'b1);
          3'd2:    tour_raddr = CITY_W'(j_q);
          3'd3:    tour_raddr = CITY_W'(j1);
          default: tour_raddr = '0;
        endcase
        case (sub_q)
          3'd1:    ci_d  = tour_rdata;
          3'd2:    ci1_d = tour_rdata;
          3'd3:    cj_d  = tour_rdata;
          3'd4:    cj1_d = tour_rdata;
          default: ;
        endcase
        if (sub_q == 3'd4) begin
          sub_d   = '0;
          state_d = ST_D_RD;
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      ST_D_RD: begin
        case (sub_q)
          3'd0:    begin dist_a = ci_q;  dist_b = cj_q;  end
          3'd1:    begin dist_a = ci1_q; dist_b = cj1_q; end
          3'd2:    begin dist_a = ci_q;  dist_b = ci1_q; end
          3'd3:    begin dist_a = cj_q;  dist_b = cj1_q; end
          default: ;
        endcase
        case (sub_q)
          3'd1:    nw_d = (DIST_W+1)'(dist_rdata);
          3'd2:    nw_d = nw_q + (DIST_W+1)'(dist_rdata);
          3'd3:    od_d = (DIST_W+1)'(dist_rdata);
          3'd4:    od_d = od_q + (DIST_W+1)'(dist_rdata);
          default: ;
        endcase
        if (sub_q == 3'd4) begin
          state_d = ST_CMP;
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      ST_CMP: begin
        if (nw_q < od_q) begin
          changed_d = 1'b1;
          l_d       = i_q + 1'b1;
          r_d       = j_q;
          sub_d     = '0;
          state_d   = ST_REV;
        end else begin
          state_d = ST_NEXT_J;
        end
      end
      ST_REV: begin
        // Swap the ends of the segment, then close in
        case (sub_q)
          3'd0: begin
            tour_raddr = CITY_W'(l_q);
            sub_d      = 3'd1;
          end
          3'd1: begin
            tour_raddr = CITY_W'(r_q);
            tl_d       = tour_rdata;
            sub_d      = 3'd2;
          end
          3'd2: begin
            tour_we    = 1'b1;
            tour_waddr = CITY_W'(l_q);
            tour_wdata = tour_rdata;
            sub_d      = 3'd3;
          end
          default: begin
            tour_we    = 1'b1;
            tour_waddr = CITY_W'(r_q);
            tour_wdata = tl_q;
            l_d        = l_q + 1'b1;
            r_d        = r_q - 1'b1;
            sub_d      = '0;
            if (l_q + NCNT_W'(2) >= r_q) begin
              state_d = ST_NEXT_J;
            end
          end
        endcase
      end
      ST_NEXT_J: begin
        sub_d = '0;
        if (j_q + 1'b1 < n_q) begin
          j_d     = j_q + 1'b1;
          state_d = ST_T_RD;
        end else if (i_q + NCNT_W'(3) < n_q) begin
          i_d     = i_q + 1'b1;
          j_d     = i_q + NCNT_W'(3);
          state_d = ST_T_RD;
        end else if (changed_q && (passes_q < max_passes_q)) begin
          state_d = ST_PASS_BEGIN;
        end else begin
          k_d     = '0;
          total_d = '0;
          state_d = ST_LEN_A;
        end
      end
      ST_LEN_A: begin
        tour_raddr = (k_q == n_q) ? '0 : CITY_W'(k_q);
        state_d    = ST_LEN_B;
      end
      ST_LEN_B: begin
        dist_a  = prev_q;
        dist_b  = tour_rdata;
        prev_d  = tour_rdata;
        state_d = ST_LEN_C;
      end
      ST_LEN_C: begin
        if (k_q != '0) begin
          total_d = total_q + LEN_W'(dist_rdata);
        end
        if (k_q == n_q) begin
          state_d = ST_BEST;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_LEN_A;
        end
      end
      ST_BEST: begin
        if (!best_v_q || (total_q < best_q)) begin
          best_d   = total_q;
          best_v_d = 1'b1;
          k_d      = '0;
          state_d  = ST_COPY;
        end else begin
          state_d = ST_NEXT_S;
        end
      end
      ST_COPY: begin
        tour_raddr = CITY_W'(k_q);
        if (k_q != '0) begin
          best_we    = 1'b1;
          best_waddr = CITY_W'(k_q - 1'b1);
          best_wdata = tour_rdata;
        end
        if (k_q == n_q) begin
          state_d = ST_NEXT_S;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_NEXT_S: begin
        if (NCNT_W'(s_q) + 1'b1 < starts) begin
          s_d     = s_q + 1'b1;
          state_d = ST_NN_INIT;
        end else begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        best_raddr = CITY_W'(k_q);
        state_d    = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_city_d  = best_rdata;
        out_len_d   = best_q;
        out_empty_d = 1'b0;
        out_last_d  = (k_q + 1'b1 == n_q);
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        // Hold the word until taken
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      entry_q      <= '0;
      city_count_q <= '0;
      max_passes_q <= MAX_PASSES_RST;
      visited_q    <= '0;
      n_q          <= '0;
      s_q          <= '0;
      step_q       <= '0;
      scan_q       <= '0;
      jp_v_q       <= 1'b0;
      found_q      <= 1'b0;
      passes_q     <= '0;
      changed_q    <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      l_q          <= '0;
      r_q          <= '0;
      sub_q        <= '0;
      best_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      entry_q     <= entry_d;
      visited_q   <= visited_d;
      n_q         <= n_d;
      s_q         <= s_d;
      step_q      <= step_d;
      scan_q      <= scan_d;
      jp_v_q      <= jp_v_d;
      found_q     <= found_d;
      passes_q    <= passes_d;
      changed_q   <= changed_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      l_q         <= l_d;
      r_q         <= r_d;
      sub_q       <= sub_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_CITY_COUNT: city_count_q <= cfg_i.data[NCNT_W-1:0];
          CFG_MAX_PASSES: max_passes_q <= cfg_i.data[PASS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    jp_q        <= jp_d;
    bn_q        <= bn_d;
    prev_q      <= prev_d;
    tl_q        <= tl_d;
    ci_q        <= ci_d;
    ci1_q       <= ci1_d;
    cj_q        <= cj_d;
    cj1_q       <= cj1_d;
    bd_q        <= bd_d;
    nw_q        <= nw_d;
    od_q        <= od_d;
    total_q     <= total_d;
    best_q      <= best_d;
    out_city_q  <= out_city_d;
    out_len_q   <= out_len_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  `TSP_ASSERT_SAME(a_load_not_with_output, in_i.ready, !out_o.valid,
                   "input open while a word waits")
  `TSP_ASSERT_SAME(a_visited_tracks_step, state_q == ST_NN_SCAN,
                   $countones(visited_q) == int'(step_q),
                   "visited count differs from tour step")
  `TSP_ASSERT_SAME(a_rev_in_order, state_q == ST_REV, l_q < r_q, "segment ends crossed")
  `TSP_ASSERT_NEXT(a_best_after_first, state_q == ST_BEST, best_v_q,
                   "best tour not marked after compare")

endmodule

### bench/tsp_tour_checker.sv
// ----------------------------------------------------------------------------
// TSP solver tour checker
// Watches the entry, register and tour channels, predicts every tour word from
// its own copy of the distance matrix and registers, and compares field by field.
// ----------------------------------------------------------------------------
module tsp_tour_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tsp_in_if    in_w,
  tsp_out_if   out_w,
  tsp_cfg_if   cfg_w,
  output int   fail_count_o,
  output int   pending_o
);
  import tsp_pkg::*;

  typedef struct packed {
    city_t city;
    len_t  length;
    logic  empty;
    logic  fin;
  } tour_word_t;

  tour_word_t      tour_words_due[$];
  dist_t           dmatrix[STORE_DEPTH];
  int unsigned     loaded;
  logic [5:0]      n_reg;
  logic [7:0]      pass_limit;
  city_t           route[MAX_CITIES];
  city_t           champion[MAX_CITIES];
  int              fails;

  assign fail_count_o = fails;
  assign pending_o    = tour_words_due.size();

  function automatic longint unsigned hop_cost(int unsigned n, int unsigned a, int unsigned b);
    int unsigned idx;
    idx = a * n + b;
    if (idx >= STORE_DEPTH) return 0;
    return dmatrix[idx];
  endfunction

  function automatic void greedy_route(int unsigned n, int unsigned first);
    logic [MAX_CITIES-1:0] seen;
    int unsigned           cur, bn;
    longint unsigned       bd, d;
    bit                    found;
    seen = '0;
    cur = first;
    seen[cur] = 1'b1;
    route[0] = city_t'(cur);
    for (int unsigned step = 1; step < n; step++) begin
      found = 0;
      bd = 0;
      bn = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (!seen[j]) begin
          d = hop_cost(n, cur, j);
          // lowest index wins a tie: only a strictly shorter hop replaces it
          if (!found || d < bd) begin
            found = 1;
            bd = d;
            bn = j;
          end
        end
      end
      seen[bn] = 1'b1;
      route[step] = city_t'(bn);
      cur = bn;
    end
  endfunction

  function automatic void untangle(int unsigned n);
    bit              changed;
    int unsigned     passes, l, r;
    longint unsigned fresh, old;
    city_t           t;
    if (n < 4) return;
    changed = 1;
    passes = 0;
    while (changed && passes < pass_limit) begin
      changed = 0;
      passes++;
      for (int unsigned i = 0; i + 1 < n; i++) begin
        for (int unsigned j = i + 2; j < n; j++) begin
          fresh = hop_cost(n, route[i], route[j]) + hop_cost(n, route[i+1], route[(j+1) % n]);
          old   = hop_cost(n, route[i], route[i+1]) + hop_cost(n, route[j], route[(j+1) % n]);
          if (fresh < old) begin
            l = i + 1;
            r = j;
            while (l < r) begin
              t = route[l];
              route[l] = route[r];
              route[r] = t;
              l++;
              r--;
            end
            changed = 1;
          end
        end
      end
    end
  endfunction

  function automatic void solve_and_queue(int unsigned n);
    bit              best_ok;
    longint unsigned best_len, len;
    int unsigned     starts, first;
    tour_word_t      w;
    best_ok = 0;
    best_len = 0;
    starts = (n <= NUM_STARTS) ? n : NUM_STARTS;
    for (int unsigned s = 0; s < starts; s++) begin
      first = (n <= NUM_STARTS) ? s : (s * n) / NUM_STARTS;
      greedy_route(n, first);
      untangle(n);
      len = 0;
      for (int unsigned i = 0; i < n; i++) len += hop_cost(n, route[i], route[(i+1) % n]);
      // keep the first strictly shortest tour
      if (!best_ok || len < best_len) begin
        best_ok = 1;
        best_len = len;
        champion = route;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      w.city = champion[k];
      w.length = len_t'(best_len);
      w.empty = 1'b0;
      w.fin = (k + 1 == n);
      tour_words_due = {tour_words_due, w};
    end
  endfunction

  function automatic void take_entry(dist_t d, logic last);
    int unsigned n;
    tour_word_t  w;
    if (loaded < STORE_DEPTH) dmatrix[loaded] = d;
    if (loaded <= STORE_DEPTH) loaded++;
    if (!last) return;
    n = n_reg;
    if (n < 2 || n > MAX_CITIES || loaded != n * n) begin
      w = '{city: '0, length: '0, empty: 1'b1, fin: 1'b1};
      tour_words_due = {tour_words_due, w};
    end else begin
      solve_and_queue(n);
    end
    loaded = 0;
  endfunction

  function automatic void check_word(tour_word_t got);
    tour_word_t want;
    if (tour_words_due.size() == 0) begin
      $display("%0t: tour word with none due: city %0d length %0d empty %0b last %0b",
               $time, got.city, got.length, got.empty, got.fin);
      fails++;
      return;
    end
    want = tour_words_due.pop_front();
    if (got.city !== want.city) begin
      $display("%0t: city expected %0d actual %0d", $time, want.city, got.city);
      fails++;
    end
    if (got.length !== want.length) begin
      $display("%0t: tour_length expected %0d actual %0d", $time, want.length, got.length);
      fails++;
    end
    if (got.empty !== want.empty) begin
      $display("%0t: empty_tour expected %0b actual %0b", $time, want.empty, got.empty);
      fails++;
    end
    if (got.fin !== want.fin) begin
      $display("%0t: last_city expected %0b actual %0b", $time, want.fin, got.fin);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_words_due.delete();
      loaded     = 0;
      n_reg      = '0;
      pass_limit = MAX_PASSES_RST;
      fails      = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        if (cfg_w.index == CFG_CITY_COUNT) n_reg = cfg_w.data[5:0];
        else if (cfg_w.index == CFG_MAX_PASSES) pass_limit = cfg_w.data;
      end
      if (in_w.valid && in_w.ready) take_entry(in_w.distance, in_w.last_entry);
      if (out_w.valid && out_w.ready)
        check_word('{city: out_w.city, length: out_w.tour_length,
                     empty: out_w.empty_tour, fin: out_w.last_city});
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// TSP solver testbench
// Loads distance matrices of many sizes and shapes, sweeps both registers and
// leaves all checking to the tour checker; gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;
  import tsp_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   cycles = 0;
  int   sent = 0;
  bit   calm = 0;   // hold both sides free of idling

  tsp_in_if  in_ch ();
  tsp_out_if out_ch ();
  tsp_cfg_if cfg_ch ();

  tsp_nearest_neighbor_two_opt DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tsp_tour_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_w        (in_ch),
    .out_w       (out_ch),
    .cfg_w       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #6 clk = ~clk;

  // Abandon the run if the solver hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[tsp_nearest_neighbor_two_opt] ERROR");
      $finish;
    end
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Tour sink: stall a random number of cycles before each word
  initial begin
    int st;
    out_ch.ready = 1'b0;
    forever begin
      st = idle_draw();
      @(negedge clk);
      if (st > 0) begin
        out_ch.ready <= 1'b0;
        repeat (st) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offer one matrix word; valid stays high afterwards until the next gap or stop
  task automatic send_entry(dist_t d, logic last);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.distance   <= d;
    in_ch.last_entry <= last;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic stop_entries();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every due tour word is out, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // kind 0: full range, 1: tiny range full of ties, 2: only the extremes
  function automatic dist_t pick_distance(int kind);
    case (kind)
      0:       return dist_t'($urandom_range(0, 65535));
      1:       return dist_t'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic load_matrix(int count, int kind);
    for (int k = 0; k < count; k++) send_entry(pick_distance(kind), k == count - 1);
    stop_entries();
  endtask

  initial begin
    int n, kind, mode, count, half;
    in_ch.valid = 1'b0;
    in_ch.distance = '0;
    in_ch.last_entry = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CITY_COUNT;
    cfg_ch.data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: no cities at reset, one city, two cities at the extremes,
    // three cities all tied, short and long loads
    load_matrix(1, 0);
    drain();
    write_reg(CFG_CITY_COUNT, 8'd1);
    load_matrix(1, 2);
    drain();
    write_reg(CFG_CITY_COUNT, 8'd2);
    write_reg(CFG_MAX_PASSES, 8'd1);
    send_entry(16'h0000, 1'b0);
    send_entry(16'hFFFF, 1'b0);
    send_entry(16'h0000, 1'b0);
    send_entry(16'hFFFF, 1'b1);
    stop_entries();
    drain();
    write_reg(CFG_CITY_COUNT, 8'd3);
    for (int k = 0; k < 9; k++) send_entry(16'h0000, k == 8);
    stop_entries();
    drain();
    write_reg(CFG_CITY_COUNT, 8'd2);
    load_matrix(3, 0);
    drain();
    load_matrix(5, 0);
    drain();

    // Random problems, mostly well formed and small
    while (sent < 150) begin
      mode = $urandom_range(0, 9);
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n = $urandom_range(2, 6);
        7, 8:                n = $urandom_range(7, 10);
        default:             n = $urandom_range(11, 14);
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_MAX_PASSES, 8'd0);
        1:       write_reg(CFG_MAX_PASSES, 8'd1);
        2:       write_reg(CFG_MAX_PASSES, 8'd2);
        3:       write_reg(CFG_MAX_PASSES, 8'd255);
        default: write_reg(CFG_MAX_PASSES, 8'($urandom_range(0, 255)));
      endcase
      count = n * n;
      if (mode == 0) begin
        // wrong entry count, either side
        count = $urandom_range(0, 1) ? count + $urandom_range(1, 3)
                                     : count - $urandom_range(1, 3);
        write_reg(CFG_CITY_COUNT, 8'(n));
        load_matrix(count, kind);
      end else if (mode == 1) begin
        // raw register value: oversized, tiny or any bit pattern
        write_reg(CFG_CITY_COUNT, 8'($urandom_range(0, 255)));
        load_matrix(count, kind);
      end else if (mode == 2) begin
        // city count rewritten while the matrix is loading
        write_reg(CFG_CITY_COUNT, 8'($urandom_range(0, 63)));
        half = count / 2;
        for (int k = 0; k < half; k++) send_entry(pick_distance(kind), 1'b0);
        stop_entries();
        write_reg(CFG_CITY_COUNT, 8'(n));
        for (int k = half; k < count; k++) send_entry(pick_distance(kind), k == count - 1);
        stop_entries();
      end else begin
        write_reg(CFG_CITY_COUNT, 8'(n));
        load_matrix(count, kind);
      end
      drain();
    end

    // Closing problems: a tight pass limit, then the full limit with ties, then four cities
    calm = 1;
    write_reg(CFG_CITY_COUNT, 8'd8);
    write_reg(CFG_MAX_PASSES, 8'd2);
    load_matrix(8 * 8, 0);
    drain();
    calm = 0;
    write_reg(CFG_CITY_COUNT, 8'd7);
    write_reg(CFG_MAX_PASSES, 8'd255);
    load_matrix(7 * 7, 1);
    drain();
    write_reg(CFG_CITY_COUNT, 8'd4);
    load_matrix(16, 0);
    drain();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[tsp_nearest_neighbor_two_opt] OK");
    end else begin
      $display("[tsp_nearest_neighbor_two_opt] ERROR");
    end
    $finish;
  end

endmodule
